@@ rtl/pbld_pkg.sv @@
`default_nettype none
package pbld_pkg;

  localparam int NUM_W    = 26;
  localparam int QUO_W    = 22;
  localparam int RES_W    = 20;
  localparam int OFF_W    = 20;
  localparam int DIV_STEPS = QUO_W / 2;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  typedef enum logic [2:0] {
    REG_THRESHOLD,
    REG_PADDING,
    REG_SCALE,
    REG_ORIG_W,
    REG_ORIG_H,
    REG_RESIZED_W,
    REG_RESIZED_H,
    REG_KP_COUNT
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] box_width;
    logic signed [15:0] box_height;
    logic [15:0]        confidence;
  } pbld_in_t;

  typedef struct packed {
    logic                    kind;
    logic signed [RES_W-1:0] x_first;
    logic signed [RES_W-1:0] y_first;
    logic signed [RES_W-1:0] x_second;
    logic signed [RES_W-1:0] y_second;
    logic [15:0]             score;
    logic [4:0]              point_index;
    logic                    last;
  } pbld_out_t;

  typedef struct packed {
    logic                  kind;
    logic [3:0][NUM_W-1:0] num;
    logic [15:0]           score;
    logic [4:0]            point_index;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic [15:0]             threshold;
    logic [4:0]              count;
    logic signed [OFF_W-1:0] off_left;
    logic signed [OFF_W-1:0] off_top;
    logic [15:0]             scale;
    logic [17:0]             width_lim;
    logic [17:0]             height_lim;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/pbld_front.sv @@
`default_nettype none
module pbld_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  pbld_pkg::pbld_in_t  in_data,
  input  pbld_pkg::cfg_t      cfg,
  input  wire                 q_full,
  output logic                push,
  output pbld_pkg::job_t      job
);
  import pbld_pkg::*;

  logic                    kept_r, kept_nxt;
  logic [4:0]              seen_r, seen_nxt;
  logic                    accept;
  logic signed [NUM_W-1:0] cx2, cy2, bw, bh, offx, offy, xb, yb;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  assign cx2  = {{9{in_data.coord_x[15]}}, in_data.coord_x, 1'b0};
  assign cy2  = {{9{in_data.coord_y[15]}}, in_data.coord_y, 1'b0};
  assign bw   = {{10{in_data.box_width[15]}}, in_data.box_width};
  assign bh   = {{10{in_data.box_height[15]}}, in_data.box_height};
  assign offx = {cfg.off_left[OFF_W-1], cfg.off_left, 5'b0};
  assign offy = {cfg.off_top[OFF_W-1], cfg.off_top, 5'b0};
  assign xb   = cx2 - offx;
  assign yb   = cy2 - offy;

  always_comb begin
    kept_nxt = kept_r;
    seen_nxt = seen_r;
    push     = 1'b0;
    job      = '0;
    job.score = in_data.confidence;
    if (in_data.func == FUNC_HEADER) begin
      job.kind   = KIND_BOX;
      job.num[0] = xb - bw;
      job.num[1] = yb - bh;
      job.num[2] = xb + bw;
      job.num[3] = yb + bh;
      job.last   = (cfg.count == 5'd0);
      seen_nxt   = '0;
      kept_nxt   = (in_data.confidence > cfg.threshold);
      push       = accept & kept_nxt;
    end else begin
      job.kind        = KIND_POINT;
      job.num[0]      = xb;
      job.num[1]      = yb;
      job.point_index = seen_r;
      job.last        = (seen_r + 5'd1 == cfg.count);
      if (kept_r && seen_r < cfg.count) begin
        push     = accept;
        seen_nxt = seen_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= 1'b0;
      seen_r <= '0;
    end else if (accept) begin
      kept_r <= kept_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pbld_queue.sv @@
`default_nettype none
module pbld_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  pbld_pkg::job_t  push_job,
  output logic            full,
  input  wire             pop,
  output pbld_pkg::job_t  pop_job,
  output logic            nonempty
);
  import pbld_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full     = (fill_r == 2'd2);
  assign nonempty = (fill_r != 2'd0);
  assign pop_job  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/pbld_back.sv @@
`default_nettype none
module pbld_back (
  input  wire                clk,
  input  wire                rst_n,
  input  pbld_pkg::cfg_t     cfg,
  input  wire                q_nonempty,
  input  pbld_pkg::job_t     q_job,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_stall,
  output pbld_pkg::pbld_out_t out_data
);
  import pbld_pkg::*;

  back_state_t             state_r, state_nxt;
  job_t                    job_r;
  logic [1:0]              k_r;
  logic [15:0]             rem_r;
  logic [QUO_W-1:0]        lo_r, q_r, q_nxt, q_fin;
  logic                    neg_r, ovf_r;
  logic [3:0]              step_r;
  logic [3:0][RES_W-1:0]   res_r;
  logic                    out_valid_r;
  pbld_out_t               out_r;
  logic                    load_out, last_step, last_div;

  logic [NUM_W-1:0]        num, mag;
  logic [16:0]             r1, r2;
  logic [15:0]             r1s, r2s;
  logic                    ge1, ge2;
  logic signed [23:0]      v, lim;
  logic [RES_W-1:0]        res_val;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign num       = job_r.num[k_r];
  assign mag       = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign last_step = (step_r == 4'(DIV_STEPS - 1));
  assign last_div  = (job_r.kind == KIND_BOX) ? (k_r == 2'd3) : (k_r == 2'd1);

  // two restoring steps a cycle
  always_comb begin
    r1    = {rem_r, lo_r[QUO_W-1]};
    ge1   = (r1 >= {1'b0, cfg.scale});
    r1s   = ge1 ? 16'(r1 - {1'b0, cfg.scale}) : r1[15:0];
    r2    = {r1s, lo_r[QUO_W-2]};
    ge2   = (r2 >= {1'b0, cfg.scale});
    r2s   = ge2 ? 16'(r2 - {1'b0, cfg.scale}) : r2[15:0];
    q_nxt = {q_r[QUO_W-3:0], ge1, ge2};
  end

  always_comb begin
    q_fin = ovf_r ? '1 : q_nxt;
    v     = neg_r ? -$signed({2'b0, q_fin}) : $signed({2'b0, q_fin});
    lim   = $signed({6'b0, k_r[0] ? cfg.height_lim : cfg.width_lim});
    if (job_r.kind == KIND_BOX) begin
      if (!k_r[1] && v < 0) v = '0;
      if (k_r[1] && v > lim) v = lim;
    end
    if (v > 24'sd524287) res_val = {1'b0, {(RES_W-1){1'b1}}};
    else if (v < -24'sd524288) res_val = {1'b1, {(RES_W-1){1'b0}}};
    else res_val = v[RES_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_nonempty) state_nxt = BK_LOAD;
      BK_LOAD: state_nxt = BK_DIV;
      BK_DIV: begin
        if (last_step) state_nxt = last_div ? BK_DONE : BK_LOAD;
      end
      BK_DONE: if (!out_valid_r || !out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_IDLE: pop      = q_nonempty;
      BK_DONE: load_out = !out_valid_r || !out_stall;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (pop) k_r <= '0;
      else if (state_r == BK_DIV && last_step) k_r <= k_r + 2'd1;
      if (state_r == BK_LOAD) step_r <= '0;
      else if (state_r == BK_DIV) step_r <= step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= q_job;
    if (state_r == BK_LOAD) begin
      neg_r <= num[NUM_W-1];
      ovf_r <= ({1'b0, mag[NUM_W-1:11]} >= cfg.scale);
      rem_r <= {1'b0, mag[NUM_W-1:11]};
      lo_r  <= {mag[10:0], 11'b0};
      q_r   <= '0;
    end else if (state_r == BK_DIV) begin
      rem_r <= r2s;
      lo_r  <= {lo_r[QUO_W-3:0], 2'b0};
      q_r   <= q_nxt;
      if (last_step) res_r[k_r] <= res_val;
    end
    if (load_out) begin
      out_r.kind        <= job_r.kind;
      out_r.x_first     <= res_r[0];
      out_r.y_first     <= res_r[1];
      out_r.x_second    <= (job_r.kind == KIND_BOX) ? res_r[2] : '0;
      out_r.y_second    <= (job_r.kind == KIND_BOX) ? res_r[3] : '0;
      out_r.score       <= job_r.score;
      out_r.point_index <= job_r.point_index;
      out_r.last        <= job_r.last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pose_box_letterbox_decode_unit.sv @@
`default_nettype none
// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   pbld_in_t
// out_      output     out_valid / out_stall pbld_out_t
// apb       input      psel penable pwrite   register file, 32 bit data
//
// a box needs four divisions by the scale and a keypoint two: every division runs
// through one shared two-bit-per-cycle divider
// dropped headers and surplus keypoints are absorbed in the front
// synchronous active-low reset clears control state and loads register defaults
// a two-entry queue lets the front keep taking items while the back or out_ stalls
module pose_box_letterbox_decode_unit #(
  parameter int MODEL_SIZE = 640,
  parameter int LEFT_ALIGN = 16,
  parameter int MAX_POINTS = 17
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  pbld_pkg::pbld_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output pbld_pkg::pbld_out_t  out_data,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [4:0]            paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import pbld_pkg::*;

  logic [15:0] thr_r, scale_r;
  logic        pad_r;
  logic [13:0] ow_r, oh_r;
  logic [9:0]  rw_r, rh_r;
  logic [4:0]  cnt_r;
  reg_idx_t    widx;
  logic        wr_en;

  logic [15:0]       s_eff;
  logic [30:0]       pw, ph;
  logic [18:0]       rw_sel, rh_sel;
  logic signed [20:0] dw, dh, hw, hh;
  logic signed [OFF_W-1:0] l_raw, t_raw, l_fin, t_fin;
  cfg_t        cfg;

  logic        push, q_full, pop, q_nonempty;
  job_t        push_job, pop_job;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      pad_r   <= 1'b0;
      scale_r <= 16'd4096;
      ow_r    <= 14'd640;
      oh_r    <= 14'd640;
      rw_r    <= 10'd640;
      rh_r    <= 10'd640;
      cnt_r   <= 5'd17;
    end else if (wr_en) begin
      case (widx)
        REG_THRESHOLD: thr_r   <= pwdata[15:0];
        REG_PADDING:   pad_r   <= pwdata[0];
        REG_SCALE:     scale_r <= pwdata[15:0];
        REG_ORIG_W:    ow_r    <= pwdata[13:0];
        REG_ORIG_H:    oh_r    <= pwdata[13:0];
        REG_RESIZED_W: rw_r    <= pwdata[9:0];
        REG_RESIZED_H: rh_r    <= pwdata[9:0];
        REG_KP_COUNT:  cnt_r   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_THRESHOLD: prdata = {16'b0, thr_r};
      REG_PADDING:   prdata = {31'b0, pad_r};
      REG_SCALE:     prdata = {16'b0, scale_r};
      REG_ORIG_W:    prdata = {18'b0, ow_r};
      REG_ORIG_H:    prdata = {18'b0, oh_r};
      REG_RESIZED_W: prdata = {22'b0, rw_r};
      REG_RESIZED_H: prdata = {22'b0, rh_r};
      REG_KP_COUNT:  prdata = {27'b0, cnt_r};
      default:       prdata = '0;
    endcase
  end

  // letterbox offsets
  always_comb begin
    s_eff = (scale_r == 16'd0) ? 16'd4096 : scale_r;
    pw    = {17'b0, ow_r} * {15'b0, s_eff} + 31'd2048;
    ph    = {17'b0, oh_r} * {15'b0, s_eff} + 31'd2048;
    if ({3'b0, rw_r} == 13'(MODEL_SIZE) && {3'b0, rh_r} == 13'(MODEL_SIZE)) begin
      rw_sel = pw[30:12];
      rh_sel = ph[30:12];
    end else begin
      rw_sel = {9'b0, rw_r};
      rh_sel = {9'b0, rh_r};
    end
    dw    = $signed(21'(MODEL_SIZE)) - $signed({2'b0, rw_sel});
    dh    = $signed(21'(MODEL_SIZE)) - $signed({2'b0, rh_sel});
    hw    = (dw + $signed({20'b0, dw[20]})) >>> 1;
    hh    = (dh + $signed({20'b0, dh[20]})) >>> 1;
    l_raw = hw[OFF_W-1:0];
    t_raw = hh[OFF_W-1:0];
    if (pad_r) begin
      l_fin = l_raw;
      t_fin = t_raw;
    end else begin
      t_fin = t_raw[0] ? t_raw - $signed(OFF_W'(1)) : t_raw;
      if (l_raw < LEFT_ALIGN) l_fin = '0;
      else l_fin = OFF_W'((l_raw / LEFT_ALIGN) * LEFT_ALIGN);
    end
  end

  always_comb begin
    cfg.threshold  = thr_r;
    cfg.count      = (cnt_r > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : cnt_r;
    cfg.off_left   = l_fin;
    cfg.off_top    = t_fin;
    cfg.scale      = s_eff;
    cfg.width_lim  = {ow_r, 4'b0};
    cfg.height_lim = {oh_r, 4'b0};
  end

  pbld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  pbld_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .nonempty (q_nonempty)
  );

  pbld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_job      (pop_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_nonempty) else $error("queue read while empty");

  a_point_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_POINT) |->
      (out_data.x_second == '0 && out_data.y_second == '0))
    else $error("keypoint result with box corners");

  a_box_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_BOX) |->
      (out_data.point_index == '0 && !out_data.x_first[RES_W-1]
       && !out_data.y_first[RES_W-1]))
    else $error("box result malformed");

endmodule
`default_nettype wire
